// ----- hw/rtl/hdbb_pkg.sv -----
// hdbb_pkg: sizes, command and status codes, controller states and the
// command/status structs shared by the dirty bitmap controller and datapath
// no dependencies
`default_nettype none

package hdbb_pkg;

   localparam int LEVEL_ENTRIES = 32;

   localparam int IDX_BITS  = 5;
   localparam int OFF_BITS  = 3;
   localparam int TOP_SHIFT = 13;
   localparam int MID_SHIFT = 8;
   localparam int INDEX_W   = 18;
   localparam int CMD_W     = 2;
   localparam int BYTE_DW   = 8;
   localparam int CNT_W     = 9;

   localparam int GROUPS = LEVEL_ENTRIES * LEVEL_ENTRIES;
   localparam int BYTES  = GROUPS * LEVEL_ENTRIES;
   localparam int GRP_W  = $clog2(GROUPS);
   localparam int BYTE_W = $clog2(BYTES);

   localparam logic [CMD_W-1:0] CMD_DIRTY = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_NOT_PRESENT = 1'b1;

   typedef enum logic [2:0] {
      S_INIT_SWEEP,
      S_IDLE,
      S_LOOKUP,
      S_HOLD,
      S_CLEAR_SWEEP
   } state_type;

   typedef struct packed {
      logic accept;
      logic lookup;
      logic push_lookup;
      logic push_pending;
      logic sweep;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic sweep_last;
   } dp_status_type;

   function automatic logic in_range(input logic [IDX_BITS-1:0] idx);
      return 32'(idx) < LEVEL_ENTRIES;
   endfunction

   function automatic logic [GRP_W-1:0] grp_addr(input logic [IDX_BITS-1:0] top,
                                                 input logic [IDX_BITS-1:0] mid);
      return GRP_W'(32'(top) * LEVEL_ENTRIES + 32'(mid));
   endfunction

   function automatic logic [BYTE_W-1:0] byte_addr(input logic [GRP_W-1:0] grp,
                                                   input logic [IDX_BITS-1:0] low);
      return BYTE_W'(32'(grp) * LEVEL_ENTRIES + 32'(low));
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hierarchical_dirty_block_bitmap_top.sv -----
// hierarchical_dirty_block_bitmap_top: dirty bitmap block, controller plus datapath
// depends on hdbb_pkg, hdbb_ctrl, hdbb_dpath
//
//   channel  | dir | handshake           | fields
//   req      | in  | req_valid/req_stall | req_cmd[1:0], req_block_index[17:0]
//   rsp      | out | rsp_valid/rsp_stall | rsp_status
//
// mark dirty / mark clean / unused command: a registered read of the byte store and
// count store, then any write back in the next cycle; the next request waits for idle
// clear-all: one store entry a cycle, over all BYTES (32768) entries before the reply
// after reset the same sweep clears all BYTES entries with req_stall high
// a finished response waits in the output register; the next request is taken
// while it waits, and the controller holds only when a second one is ready
`default_nettype none

module hierarchical_dirty_block_bitmap_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [hdbb_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [hdbb_pkg::INDEX_W-1:0]   req_block_index,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_status
);

   hdbb_pkg::dp_cmd_type    dp_cmd;
   hdbb_pkg::dp_status_type dp_status;

   hdbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   hdbb_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_block_index (req_block_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/hdbb_ctrl.sv -----
// hdbb_ctrl: controller state machine for the dirty bitmap
// depends on hdbb_pkg; drives the datapath through hdbb_pkg::dp_cmd_type
`default_nettype none

module hdbb_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [hdbb_pkg::CMD_W-1:0]   req_cmd,
   output logic                              req_stall,
   input  wire hdbb_pkg::dp_status_type      dp_status,
   output hdbb_pkg::dp_cmd_type              dp_cmd
);

   hdbb_pkg::state_type state_ff;
   hdbb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hdbb_pkg::S_INIT_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      dp_cmd    = '0;
      case (state_ff)
         hdbb_pkg::S_INIT_SWEEP: begin
            dp_cmd.sweep = 1'b1;
            if (dp_status.sweep_last) begin
               state_in = hdbb_pkg::S_IDLE;
            end
         end
         hdbb_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.accept = 1'b1;
               if (req_cmd == hdbb_pkg::CMD_CLEAR) begin
                  state_in = hdbb_pkg::S_CLEAR_SWEEP;
               end else begin
                  state_in = hdbb_pkg::S_LOOKUP;
               end
            end
         end
         hdbb_pkg::S_LOOKUP: begin
            dp_cmd.lookup = 1'b1;
            if (dp_status.slot_free) begin
               dp_cmd.push_lookup = 1'b1;
               state_in = hdbb_pkg::S_IDLE;
            end else begin
               state_in = hdbb_pkg::S_HOLD;
            end
         end
         hdbb_pkg::S_HOLD: begin
            if (dp_status.slot_free) begin
               dp_cmd.push_pending = 1'b1;
               state_in = hdbb_pkg::S_IDLE;
            end
         end
         hdbb_pkg::S_CLEAR_SWEEP: begin
            dp_cmd.sweep = 1'b1;
            if (dp_status.sweep_last) begin
               state_in = hdbb_pkg::S_HOLD;
            end
         end
         default: begin
            state_in = hdbb_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hdbb_dpath.sv -----
// hdbb_dpath: bitmap byte store, group count store, request registers,
// sweep counter and response register; depends on hdbb_pkg
`default_nettype none

module hdbb_dpath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [hdbb_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [hdbb_pkg::INDEX_W-1:0]   req_block_index,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_status,
   input  wire hdbb_pkg::dp_cmd_type           dp_cmd,
   output hdbb_pkg::dp_status_type             dp_status
);

   logic [hdbb_pkg::BYTE_DW-1:0] bytes_mem [hdbb_pkg::BYTES];
   logic [hdbb_pkg::CNT_W-1:0]   cnt_mem   [hdbb_pkg::GROUPS];

   logic [hdbb_pkg::IDX_BITS-1:0]  req_top;
   logic [hdbb_pkg::IDX_BITS-1:0]  req_mid;
   logic [hdbb_pkg::IDX_BITS-1:0]  req_low;
   logic [hdbb_pkg::GRP_W-1:0]     req_grp;
   logic [hdbb_pkg::BYTE_W-1:0]    req_byte;

   logic [hdbb_pkg::CMD_W-1:0]     cmd_ff;
   logic [hdbb_pkg::GRP_W-1:0]     grp_ff;
   logic [hdbb_pkg::BYTE_W-1:0]    byte_ff;
   logic [hdbb_pkg::OFF_BITS-1:0]  off_ff;
   logic                           inrange_ff;
   logic [hdbb_pkg::BYTE_DW-1:0]   byte_rd_ff;
   logic [hdbb_pkg::CNT_W-1:0]     cnt_rd_ff;
   logic                           pending_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_status_ff;
   logic [hdbb_pkg::BYTE_W-1:0]    sweep_ff;

   logic [hdbb_pkg::BYTE_DW-1:0]   mask;
   logic                           hit;
   logic                           wr_ok;
   logic [hdbb_pkg::BYTE_DW-1:0]   new_byte;
   logic [hdbb_pkg::CNT_W-1:0]     new_cnt;
   logic                           status_calc;

   logic                           byte_we;
   logic [hdbb_pkg::BYTE_W-1:0]    byte_waddr;
   logic [hdbb_pkg::BYTE_DW-1:0]   byte_wdata;
   logic                           cnt_we;
   logic [hdbb_pkg::GRP_W-1:0]     cnt_waddr;
   logic [hdbb_pkg::CNT_W-1:0]     cnt_wdata;
   logic                           sweep_last;

   assign req_top  = req_block_index[hdbb_pkg::TOP_SHIFT +: hdbb_pkg::IDX_BITS];
   assign req_mid  = req_block_index[hdbb_pkg::MID_SHIFT +: hdbb_pkg::IDX_BITS];
   assign req_low  = req_block_index[hdbb_pkg::OFF_BITS +: hdbb_pkg::IDX_BITS];
   assign req_grp  = hdbb_pkg::grp_addr(req_top, req_mid);
   assign req_byte = hdbb_pkg::byte_addr(req_grp, req_low);

   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         cmd_ff     <= req_cmd;
         grp_ff     <= req_grp;
         byte_ff    <= req_byte;
         off_ff     <= req_block_index[hdbb_pkg::OFF_BITS-1:0];
         inrange_ff <= hdbb_pkg::in_range(req_top) && hdbb_pkg::in_range(req_mid) &&
                       hdbb_pkg::in_range(req_low);
      end
      if (dp_cmd.accept) begin
         pending_ff <= hdbb_pkg::STATUS_OK;
      end else if (dp_cmd.lookup) begin
         pending_ff <= status_calc;
      end
   end

   // read-modify-write result
   always_comb begin
      mask        = hdbb_pkg::BYTE_DW'(1) << off_ff;
      hit         = |(byte_rd_ff & mask);
      wr_ok       = 1'b0;
      new_byte    = byte_rd_ff;
      new_cnt     = cnt_rd_ff;
      status_calc = hdbb_pkg::STATUS_OK;
      case (cmd_ff)
         hdbb_pkg::CMD_DIRTY: begin
            if (inrange_ff && !hit) begin
               wr_ok    = 1'b1;
               new_byte = byte_rd_ff | mask;
               new_cnt  = hdbb_pkg::CNT_W'(cnt_rd_ff + 1'b1);
            end
         end
         hdbb_pkg::CMD_CLEAN: begin
            if (!inrange_ff || (cnt_rd_ff == '0)) begin
               status_calc = hdbb_pkg::STATUS_NOT_PRESENT;
            end else if (hit) begin
               wr_ok    = 1'b1;
               new_byte = byte_rd_ff & ~mask;
               new_cnt  = hdbb_pkg::CNT_W'(cnt_rd_ff - 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   assign sweep_last = sweep_ff == hdbb_pkg::BYTE_W'(hdbb_pkg::BYTES - 1);

   assign byte_we    = dp_cmd.sweep || (dp_cmd.lookup && wr_ok);
   assign byte_waddr = dp_cmd.sweep ? sweep_ff : byte_ff;
   assign byte_wdata = dp_cmd.sweep ? '0 : new_byte;
   assign cnt_we     = (dp_cmd.sweep &&
                        (sweep_ff < hdbb_pkg::BYTE_W'(hdbb_pkg::GROUPS))) ||
                       (dp_cmd.lookup && wr_ok);
   assign cnt_waddr  = dp_cmd.sweep ? sweep_ff[hdbb_pkg::GRP_W-1:0] : grp_ff;
   assign cnt_wdata  = dp_cmd.sweep ? '0 : new_cnt;

   always_ff @(posedge clock) begin
      if (byte_we) begin
         bytes_mem[byte_waddr] <= byte_wdata;
      end
      if (dp_cmd.accept) begin
         byte_rd_ff <= bytes_mem[req_byte];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (dp_cmd.accept) begin
         cnt_rd_ff <= cnt_mem[req_grp];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (dp_cmd.sweep) begin
         sweep_ff <= sweep_last ? '0 : hdbb_pkg::BYTE_W'(sweep_ff + 1'b1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.push_lookup || dp_cmd.push_pending) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.push_lookup) begin
         rsp_status_ff <= status_calc;
      end else if (dp_cmd.push_pending) begin
         rsp_status_ff <= pending_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign dp_status.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign dp_status.sweep_last = sweep_last;

   a_push_slot_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.push_lookup || dp_cmd.push_pending) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response pushed into an occupied slot");

   a_sweep_owned: assert property (@(posedge clock) disable iff (reset)
      (sweep_ff != '0) |-> dp_cmd.sweep)
      else $error("sweep counter left mid sweep");

   a_dirty_one_bit: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.lookup && wr_ok && (cmd_ff == hdbb_pkg::CMD_DIRTY)) |->
      ($countones(new_byte) == $countones(byte_rd_ff) + 1))
      else $error("dirty mark changed other than one bit");

   a_error_no_write: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.lookup && (status_calc == hdbb_pkg::STATUS_NOT_PRESENT)) |->
      (!byte_we && !cnt_we))
      else $error("store written on a not-present clean");

endmodule

`default_nettype wire
